// ===== hw/rtl/max_xor_binary_trie_assert.svh =====
// Assertion macros for the max-xor trie block.
`ifndef MAX_XOR_BINARY_TRIE_ASSERT_SVH
`define MAX_XOR_BINARY_TRIE_ASSERT_SVH

`ifndef ASSERT_OFF
// Clocked check, held off while reset is high.
`define MXT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also holds during reset.
`define MXT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MXT_ASSERT(lbl, clk, rst, prop, msg)
`define MXT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== hw/rtl/mxt_pkg.sv =====
// Shared constants, codes and control types of the max-xor trie block.
package mxt_pkg;

   localparam int KEY_BITS  = 32;
   localparam int MAX_NODES = 65536;
   localparam int NODE_BITS = $clog2(MAX_NODES);
   localparam int TOP_BITS  = NODE_BITS + 1;
   localparam int LVL_BITS  = $clog2(KEY_BITS + 1);
   localparam int KIDX_BITS = $clog2(KEY_BITS);
   localparam int CNT_BITS  = 32;

   typedef logic [1:0]           cmd_type;
   typedef logic [1:0]           status_type;
   typedef logic [31:0]          word_type;
   typedef logic [NODE_BITS-1:0] node_type;

   localparam cmd_type CMD_INSERT = 2'd0;
   localparam cmd_type CMD_DELETE = 2'd1;
   localparam cmd_type CMD_QUERY  = 2'd2;

   localparam status_type ST_OK     = 2'd0;
   localparam status_type ST_FULL   = 2'd1;
   localparam status_type ST_ABSENT = 2'd2;

   typedef struct packed {
      logic idle;
      logic clear;
      logic start;
      logic walk1;
      logic check;
      logic walk2;
      logic alloc;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic walk_end;
      logic go2;
      logic to_alloc;
      logic alloc_end;
      logic rsp_busy;
   } dp_stat_type;

endpackage

// ===== hw/rtl/mxt_if.sv =====
// Request and response channel interfaces of the max-xor trie block.
interface mxt_req_if;
   logic             valid;
   logic             ready;
   mxt_pkg::cmd_type cmd;
   mxt_pkg::word_type key;
   modport source (output valid, output cmd, output key, input ready);
   modport sink (input valid, input cmd, input key, output ready);
endinterface

interface mxt_rsp_if;
   logic                valid;
   logic                ready;
   mxt_pkg::word_type   max_xor;
   mxt_pkg::status_type status;
   modport source (output valid, output max_xor, output status, input ready);
   modport sink (input valid, input max_xor, input status, output ready);
endinterface

// ===== hw/rtl/mxt_ram.sv =====
// Generic simple dual-port RAM with registered read.
module mxt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hw/rtl/mxt_ctrl.sv =====
// Sequencer for the max-xor trie: clearing pass, check walk, update walk, reply.
module mxt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  mxt_pkg::dp_stat_type  stat,
   output mxt_pkg::ctrl_cmd_type cmd
);
   import mxt_pkg::*;

   typedef enum logic [7:0] {
      S_CLEAR  = 8'b0000_0001,
      S_IDLE   = 8'b0000_0010,
      S_WALK1  = 8'b0000_0100,
      S_CHECK  = 8'b0000_1000,
      S_WALK2  = 8'b0001_0000,
      S_ALLOC  = 8'b0010_0000,
      S_FINISH = 8'b0100_0000,
      S_SPARE  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clear_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            cmd.idle = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = S_WALK1;
            end
         end
         S_WALK1: begin
            cmd.walk1 = 1'b1;
            if (stat.walk_end) state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = stat.go2 ? S_WALK2 : S_FINISH;
         end
         S_WALK2: begin
            cmd.walk2 = 1'b1;
            if (stat.to_alloc) state_in = S_ALLOC;
            else if (stat.walk_end) state_in = S_FINISH;
         end
         S_ALLOC: begin
            cmd.alloc = 1'b1;
            if (stat.alloc_end) state_in = S_FINISH;
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            if (!stat.rsp_busy) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLEAR;
      else state_ff <= state_in;
   end
endmodule

// ===== hw/rtl/mxt_dpath.sv =====
// Trie datapath: node memories, free stack, walk registers and reply register.
module mxt_dpath (
   input  logic                  clock,
   input  logic                  reset,
   input  mxt_pkg::ctrl_cmd_type cmd,
   output mxt_pkg::dp_stat_type  stat,
   input  mxt_pkg::cmd_type      req_cmd,
   input  mxt_pkg::word_type     req_key,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output mxt_pkg::word_type     rsp_max_xor,
   output mxt_pkg::status_type   rsp_status
);
   import mxt_pkg::*;

   cmd_type               op_ff, op_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [LVL_BITS-1:0]   level_ff, level_in, depth_ff, depth_in;
   node_type              cur_ff, cur_in, prev_ff, prev_in, alloc_ff, alloc_in;
   logic                  prevb_ff, prevb_in;
   logic [KEY_BITS-1:0]   ans_ff, ans_in;
   logic                  ovf_ff, ovf_in, absent_ff, absent_in, dead_ff, dead_in;
   logic                  unl_ff, unl_in;
   logic [TOP_BITS-1:0]   ftop_ff, ftop_in, fresh_ff, fresh_in;
   node_type              clr_ff, clr_in;
   status_type            stat_ff, stat_in;
   logic                  rspv_ff, rspv_in;
   word_type              rspx_ff, rspx_in;
   status_type            rsps_ff, rsps_in;

   logic                  zc_we, oc_we, pc_we, fs_we;
   node_type              zc_wa, oc_wa, pc_wa, fs_wa, fs_ra;
   node_type              zc_wd, oc_wd, fs_wd;
   logic [CNT_BITS-1:0]   pc_wd;
   node_type              zc_rd, oc_rd, fs_rd;
   logic [CNT_BITS-1:0]   pc_rd, pc_inc, pc_dec;

   logic [KIDX_BITS-1:0]  kidx;
   logic                  kbit, at_leaf, not_root, consume;
   node_type              child_b, child_w, cand;
   logic [TOP_BITS:0]     avail;
   logic [LVL_BITS-1:0]   needed;
   logic                  fail;

   mxt_ram #(.WIDTH(NODE_BITS), .DEPTH(MAX_NODES)) u_zc (
      .clock, .wr_en(zc_we), .wr_addr(zc_wa), .wr_data(zc_wd), .rd_addr(cur_in),
      .rd_data(zc_rd));
   mxt_ram #(.WIDTH(NODE_BITS), .DEPTH(MAX_NODES)) u_oc (
      .clock, .wr_en(oc_we), .wr_addr(oc_wa), .wr_data(oc_wd), .rd_addr(cur_in),
      .rd_data(oc_rd));
   mxt_ram #(.WIDTH(CNT_BITS), .DEPTH(MAX_NODES)) u_pc (
      .clock, .wr_en(pc_we), .wr_addr(pc_wa), .wr_data(pc_wd), .rd_addr(cur_in),
      .rd_data(pc_rd));
   mxt_ram #(.WIDTH(NODE_BITS), .DEPTH(MAX_NODES)) u_fs (
      .clock, .wr_en(fs_we), .wr_addr(fs_wa), .wr_data(fs_wd), .rd_addr(fs_ra),
      .rd_data(fs_rd));

   always_comb begin
      kidx     = KIDX_BITS'(KEY_BITS - 1) - level_ff[KIDX_BITS-1:0];
      kbit     = key_ff[kidx];
      at_leaf  = (level_ff == LVL_BITS'(KEY_BITS));
      not_root = (level_ff != '0);
      child_b  = kbit ? oc_rd : zc_rd;
      child_w  = kbit ? zc_rd : oc_rd;
      pc_inc   = pc_rd + CNT_BITS'(1);
      pc_dec   = pc_rd - CNT_BITS'(1);
      cand     = (ftop_ff != '0) ? fs_rd : fresh_ff[NODE_BITS-1:0];
      avail    = {1'b0, ftop_ff} + (TOP_BITS + 1)'(MAX_NODES) - {1'b0, fresh_ff};
      needed   = LVL_BITS'(KEY_BITS) - depth_ff;
      fail     = ovf_ff || ((TOP_BITS + 1)'(needed) > avail);

      op_in = op_ff;  key_in = key_ff;  level_in = level_ff;  depth_in = depth_ff;
      cur_in = cur_ff;  prev_in = prev_ff;  prevb_in = prevb_ff;  alloc_in = alloc_ff;
      ans_in = ans_ff;  ovf_in = ovf_ff;  absent_in = absent_ff;  dead_in = dead_ff;
      unl_in = unl_ff;  ftop_in = ftop_ff;  fresh_in = fresh_ff;  clr_in = clr_ff;
      stat_in = stat_ff;  rspv_in = rspv_ff;  rspx_in = rspx_ff;  rsps_in = rsps_ff;

      zc_we = 1'b0;  zc_wa = cur_ff;  zc_wd = '0;
      oc_we = 1'b0;  oc_wa = cur_ff;  oc_wd = '0;
      pc_we = 1'b0;  pc_wa = cur_ff;  pc_wd = '0;
      fs_we = 1'b0;  fs_wa = ftop_ff[NODE_BITS-1:0];  fs_wd = cur_ff;
      consume = 1'b0;
      stat    = '0;
      stat.rsp_busy   = rspv_ff && !rsp_ready;
      stat.clear_done = (clr_ff == NODE_BITS'(MAX_NODES - 1));

      if (cmd.clear) begin
         // rebuild the reset trie: the all-zero path holding key zero once
         zc_we = 1'b1;  oc_we = 1'b1;  pc_we = 1'b1;
         zc_wa = clr_ff;  oc_wa = clr_ff;  pc_wa = clr_ff;
         zc_wd = (clr_ff < NODE_BITS'(KEY_BITS)) ? clr_ff + NODE_BITS'(1) : '0;
         pc_wd = (clr_ff <= NODE_BITS'(KEY_BITS)) ? CNT_BITS'(1) : '0;
         clr_in = clr_ff + NODE_BITS'(1);
      end

      if (cmd.start) begin
         op_in = req_cmd;  key_in = req_key[KEY_BITS-1:0];
         level_in = '0;  cur_in = '0;  depth_in = '0;  ans_in = '0;
         ovf_in = 1'b0;  absent_in = 1'b0;  dead_in = 1'b0;
      end

      if (cmd.walk1) begin
         unique case (op_ff)
            CMD_INSERT: begin
               if (not_root && (pc_rd == '1)) ovf_in = 1'b1;
               if (at_leaf || (child_b == '0)) begin
                  stat.walk_end = 1'b1;
                  depth_in      = level_ff;
               end else begin
                  cur_in   = child_b;
                  level_in = level_ff + LVL_BITS'(1);
               end
            end
            CMD_DELETE: begin
               if (not_root && (pc_rd == '0)) begin
                  absent_in     = 1'b1;
                  stat.walk_end = 1'b1;
               end else if (at_leaf) begin
                  stat.walk_end = 1'b1;
               end else if (child_b == '0) begin
                  absent_in     = 1'b1;
                  stat.walk_end = 1'b1;
               end else begin
                  cur_in   = child_b;
                  level_in = level_ff + LVL_BITS'(1);
               end
            end
            CMD_QUERY: begin
               if (at_leaf) begin
                  stat.walk_end = 1'b1;
               end else if (child_w != '0) begin
                  ans_in   = {ans_ff[KEY_BITS-2:0], 1'b1};
                  cur_in   = child_w;
                  level_in = level_ff + LVL_BITS'(1);
               end else if (child_b != '0) begin
                  ans_in   = {ans_ff[KEY_BITS-2:0], 1'b0};
                  cur_in   = child_b;
                  level_in = level_ff + LVL_BITS'(1);
               end else begin
                  dead_in       = 1'b1;
                  stat.walk_end = 1'b1;
               end
            end
            default: stat.walk_end = 1'b1;
         endcase
      end

      if (cmd.check) begin
         stat_in = ST_OK;
         if (op_ff == CMD_INSERT) begin
            if (fail) stat_in = ST_FULL;
            else stat.go2 = 1'b1;
         end else if (op_ff == CMD_DELETE) begin
            if (absent_ff) stat_in = ST_ABSENT;
            else stat.go2 = 1'b1;
         end
         if (stat.go2) begin
            level_in = '0;  cur_in = '0;  unl_in = 1'b0;
         end
      end

      if (cmd.walk2) begin
         if (op_ff == CMD_INSERT) begin
            if (not_root) begin
               pc_we = 1'b1;  pc_wd = pc_inc;
            end
            if (at_leaf) begin
               stat.walk_end = 1'b1;
            end else if (child_b != '0) begin
               cur_in   = child_b;
               level_in = level_ff + LVL_BITS'(1);
            end else begin
               // hang a new branch below the deepest existing node
               zc_we         = !kbit;  zc_wd = cand;
               oc_we         = kbit;   oc_wd = cand;
               consume       = 1'b1;
               alloc_in      = cand;
               level_in      = level_ff + LVL_BITS'(1);
               stat.to_alloc = 1'b1;
            end
         end else begin
            if (not_root) begin
               pc_we = 1'b1;  pc_wd = pc_dec;
               if (pc_dec == '0) begin
                  if (ftop_ff < TOP_BITS'(MAX_NODES)) begin
                     fs_we   = 1'b1;
                     ftop_in = ftop_ff + TOP_BITS'(1);
                  end
                  // cut the link only above the topmost emptied node
                  if (!unl_ff) begin
                     zc_we  = !prevb_ff;  zc_wa = prev_ff;
                     oc_we  = prevb_ff;   oc_wa = prev_ff;
                     unl_in = 1'b1;
                  end
               end
            end
            if (at_leaf) begin
               stat.walk_end = 1'b1;
            end else begin
               prev_in  = cur_ff;
               prevb_in = kbit;
               cur_in   = child_b;
               level_in = level_ff + LVL_BITS'(1);
            end
         end
      end

      if (cmd.alloc) begin
         zc_we = 1'b1;  oc_we = 1'b1;  pc_we = 1'b1;
         zc_wa = alloc_ff;  oc_wa = alloc_ff;  pc_wa = alloc_ff;
         pc_wd = CNT_BITS'(1);
         if (at_leaf) begin
            stat.alloc_end = 1'b1;
         end else begin
            zc_wd    = kbit ? '0 : cand;
            oc_wd    = kbit ? cand : '0;
            consume  = 1'b1;
            alloc_in = cand;
            level_in = level_ff + LVL_BITS'(1);
         end
      end

      if (consume) begin
         if (ftop_ff != '0) ftop_in = ftop_ff - TOP_BITS'(1);
         else fresh_in = fresh_ff + TOP_BITS'(1);
      end
      // keep the stack top prefetched one word ahead of each pop
      fs_ra = ftop_ff[NODE_BITS-1:0] - (consume ? NODE_BITS'(2) : NODE_BITS'(1));

      if (cmd.finish && !stat.rsp_busy) begin
         rspv_in = 1'b1;
         rspx_in = ((op_ff == CMD_QUERY) && !dead_ff) ? 32'(ans_ff) : '0;
         rsps_in = stat_ff;
      end else if (rsp_ready) begin
         rspv_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff   <= '0;
         ftop_ff  <= '0;
         fresh_ff <= TOP_BITS'(KEY_BITS + 1);
         rspv_ff  <= 1'b0;
         unl_ff   <= 1'b0;
      end else begin
         clr_ff   <= clr_in;
         ftop_ff  <= ftop_in;
         fresh_ff <= fresh_in;
         rspv_ff  <= rspv_in;
         unl_ff   <= unl_in;
      end
      op_ff     <= op_in;
      key_ff    <= key_in;
      level_ff  <= level_in;
      depth_ff  <= depth_in;
      cur_ff    <= cur_in;
      prev_ff   <= prev_in;
      prevb_ff  <= prevb_in;
      alloc_ff  <= alloc_in;
      ans_ff    <= ans_in;
      ovf_ff    <= ovf_in;
      absent_ff <= absent_in;
      dead_ff   <= dead_in;
      stat_ff   <= stat_in;
      rspx_ff   <= rspx_in;
      rsps_ff   <= rsps_in;
   end

   assign rsp_valid   = rspv_ff;
   assign rsp_max_xor = rspx_ff;
   assign rsp_status  = rsps_ff;
endmodule

// ===== hw/rtl/max_xor_binary_trie.sv =====
// Max-xor binary trie over a multiset of 32-bit keys, one trie level per cycle.
// A query takes one walk; insert and delete add an update walk after the check walk,
// which a refused insert or an absent delete skips.
// The walk rate is set by the registered read of the node memories, one node per cycle.
// Words are handled one at a time: the next is taken once the reply loads and the block is idle.
// After reset a clearing pass rebuilds all MAX_NODES (65536) entries of the node memories.
`include "max_xor_binary_trie_assert.svh"

module max_xor_binary_trie (
   input logic clock,
   input logic reset,
   mxt_req_if.sink   req_if,
   mxt_rsp_if.source rsp_if
);
   import mxt_pkg::*;

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   mxt_ctrl u_ctrl (
      .clock, .reset, .req_valid(req_if.valid), .stat, .cmd
   );

   mxt_dpath u_dpath (
      .clock, .reset, .cmd, .stat,
      .req_cmd(req_if.cmd), .req_key(req_if.key),
      .rsp_ready(rsp_if.ready), .rsp_valid(rsp_if.valid),
      .rsp_max_xor(rsp_if.max_xor), .rsp_status(rsp_if.status)
   );

   assign req_if.ready = cmd.idle;

   `MXT_ASSERT(a_one_in_flight, clock, reset, req_if.valid && req_if.ready |=> !req_if.ready, "accepted a word while busy")
   `MXT_ASSERT(a_xor_ok_only, clock, reset, rsp_if.valid && (rsp_if.max_xor != '0) |-> rsp_if.status == ST_OK, "nonzero result with error status")
   `MXT_ASSERT(a_phase_excl, clock, reset, $onehot0({cmd.clear, cmd.walk1, cmd.walk2, cmd.alloc, cmd.idle}), "overlapping datapath phases")
   `MXT_ASSERT(a_alloc_entry, clock, reset, $rose(cmd.alloc) |-> $past(cmd.walk2), "branch allocation without update walk")
endmodule
